### design/tcf_pkg.sv
// shared types, constants and tables for the tilt complementary filter
package tcf_pkg;

  // cordic configuration
  localparam int CORDIC_STEPS = 16;
  localparam int ATAN_LEN     = 24;
  localparam int CORDIC_ITERS = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;
  localparam int ITER_W       = 5;
  localparam int IN_W         = 21;
  localparam int VEC_W        = 36;
  localparam int ANG_W        = 26;
  localparam int PRE_SHIFT    = 12;
  localparam logic signed [ANG_W-1:0] ANG_90 = 26'sd5898240;

  // datapath sizes
  localparam int MUL_A_W    = 36;
  localparam int MUL_B_W    = 18;
  localparam int PROD_W     = MUL_A_W + MUL_B_W;
  localparam int SQRT_STEPS = 20;
  localparam int Q_DEPTH    = 2;
  localparam int NUM_AXES   = 3;

  localparam logic signed [16:0] ANG_MAX    = 17'sd46080;
  localparam logic [16:0]        ALPHA_ONE  = 17'd65536;
  localparam logic [7:0]         GYRO_DIV   = 8'd131;
  localparam logic [15:0]        GYRO_ROUND = 16'd65;

  // reciprocals of 131: 2^39 scale for values below 2^31, 2^24 scale below 2^16
  localparam logic [31:0] RECIP_M     = 32'd4196609267;
  localparam int          RECIP_SHIFT = 39;
  localparam logic [16:0] RECIP2_M    = 17'd128071;

  // multiplier schedule
  localparam logic [2:0] OP_A_LAST = 3'd5;
  localparam logic [2:0] OP_B_LAST = 3'd6;

  // register map
  localparam logic [2:0] REG_BLEND_WEIGHT  = 3'd0;
  localparam logic [2:0] REG_SAMPLE_PERIOD = 3'd1;
  localparam logic [2:0] REG_LEFT_LIMIT    = 3'd2;
  localparam logic [2:0] REG_RIGHT_LIMIT   = 3'd3;
  localparam logic [2:0] REG_TOP_LIMIT     = 3'd4;
  localparam logic [2:0] REG_BOTTOM_LIMIT  = 3'd5;

  localparam logic [16:0]       RST_BLEND_WEIGHT  = 17'd64225;
  localparam logic [15:0]       RST_SAMPLE_PERIOD = 16'd6554;
  localparam logic signed [8:0] RST_LEFT_LIMIT    = -9'sd10;
  localparam logic signed [8:0] RST_RIGHT_LIMIT   = 9'sd10;
  localparam logic signed [8:0] RST_TOP_LIMIT     = 9'sd10;
  localparam logic signed [8:0] RST_BOTTOM_LIMIT  = -9'sd10;

  typedef struct packed {
    logic signed [15:0] acc_x;
    logic signed [15:0] acc_y;
    logic signed [15:0] acc_z;
    logic signed [15:0] rate_x;
    logic signed [15:0] rate_y;
    logic signed [15:0] rate_z;
  } sample_t;

  typedef struct packed {
    logic [16:0]       blend_weight;
    logic [15:0]       sample_period;
    logic signed [8:0] left_limit;
    logic signed [8:0] right_limit;
    logic signed [8:0] top_limit;
    logic signed [8:0] bottom_limit;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_A,
    ST_SQRT,
    ST_ROLL_GO,
    ST_ROLL,
    ST_PITCH_GO,
    ST_PITCH,
    ST_DIV_WAIT,
    ST_MUL_B,
    ST_OUT
  } eng_state_e;

  // arctangent of 2^-i in 1/65536 degree, rounded
  function automatic logic [21:0] atan_deg16(input logic [4:0] idx);
    logic [21:0] v;
    case (idx)
      5'd0:  v = 22'd2949120;
      5'd1:  v = 22'd1740967;
      5'd2:  v = 22'd919879;
      5'd3:  v = 22'd466945;
      5'd4:  v = 22'd234379;
      5'd5:  v = 22'd117304;
      5'd6:  v = 22'd58666;
      5'd7:  v = 22'd29335;
      5'd8:  v = 22'd14668;
      5'd9:  v = 22'd7334;
      5'd10: v = 22'd3667;
      5'd11: v = 22'd1833;
      5'd12: v = 22'd917;
      5'd13: v = 22'd458;
      5'd14: v = 22'd229;
      5'd15: v = 22'd115;
      5'd16: v = 22'd57;
      5'd17: v = 22'd29;
      5'd18: v = 22'd14;
      5'd19: v = 22'd7;
      5'd20: v = 22'd4;
      5'd21: v = 22'd2;
      5'd22: v = 22'd1;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

endpackage

### design/tilt_complementary_filter_top.sv
// top level: register port, input queue and filter engine
//
// One six-axis sample (raw accelerometer and gyro, signed 16 bit) goes in per
// input transaction on in_valid_i / in_stall_o; one result (filtered roll,
// pitch, yaw in 1/256 degree and four limit flags) comes out per output
// transaction on out_valid_o / out_stall_i.
// A sample's pass from acceptance to a valid result is set by the engine's
// sequence: five products on the shared multiplier, a 20-step square root,
// two cordic passes of CORDIC_STEPS iterations each and six blend products.
// Gyro division by 131 runs alongside the square root as a reciprocal
// multiply, one axis after another. The engine works on one sample at a time.
// A two-entry queue takes new samples while the engine works; a finished
// result waits in the output register while the receiver stalls, and the
// engine holds its next result until that register frees.
// Reset clears the filter angles to zero, empties the queue and loads the
// register defaults. Registers are written over the APB port at 4*index and
// should only change while the block is idle.
module tilt_complementary_filter_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] acc_x_i,
  input  logic signed [15:0] acc_y_i,
  input  logic signed [15:0] acc_z_i,
  input  logic signed [15:0] rate_x_i,
  input  logic signed [15:0] rate_y_i,
  input  logic signed [15:0] rate_z_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [16:0] roll_out_o,
  output logic signed [16:0] pitch_out_o,
  output logic signed [16:0] yaw_out_o,
  output logic               flag_left_o,
  output logic               flag_right_o,
  output logic               flag_top_o,
  output logic               flag_bottom_o
);

  tcf_pkg::cfg_t    cfg_q;
  tcf_pkg::sample_t in_data, q_data;
  logic             q_valid, q_pop, wr_en;
  logic [2:0]       reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite && pready;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.blend_weight  <= tcf_pkg::RST_BLEND_WEIGHT;
      cfg_q.sample_period <= tcf_pkg::RST_SAMPLE_PERIOD;
      cfg_q.left_limit    <= tcf_pkg::RST_LEFT_LIMIT;
      cfg_q.right_limit   <= tcf_pkg::RST_RIGHT_LIMIT;
      cfg_q.top_limit     <= tcf_pkg::RST_TOP_LIMIT;
      cfg_q.bottom_limit  <= tcf_pkg::RST_BOTTOM_LIMIT;
    end else if (wr_en) begin
      case (reg_idx)
        tcf_pkg::REG_BLEND_WEIGHT:  cfg_q.blend_weight  <= pwdata[16:0];
        tcf_pkg::REG_SAMPLE_PERIOD: cfg_q.sample_period <= pwdata[15:0];
        tcf_pkg::REG_LEFT_LIMIT:    cfg_q.left_limit    <= pwdata[8:0];
        tcf_pkg::REG_RIGHT_LIMIT:   cfg_q.right_limit   <= pwdata[8:0];
        tcf_pkg::REG_TOP_LIMIT:     cfg_q.top_limit     <= pwdata[8:0];
        tcf_pkg::REG_BOTTOM_LIMIT:  cfg_q.bottom_limit  <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    case (reg_idx)
      tcf_pkg::REG_BLEND_WEIGHT:  prdata = {15'd0, cfg_q.blend_weight};
      tcf_pkg::REG_SAMPLE_PERIOD: prdata = {16'd0, cfg_q.sample_period};
      tcf_pkg::REG_LEFT_LIMIT:    prdata = {23'd0, cfg_q.left_limit};
      tcf_pkg::REG_RIGHT_LIMIT:   prdata = {23'd0, cfg_q.right_limit};
      tcf_pkg::REG_TOP_LIMIT:     prdata = {23'd0, cfg_q.top_limit};
      tcf_pkg::REG_BOTTOM_LIMIT:  prdata = {23'd0, cfg_q.bottom_limit};
      default:                    prdata = 32'd0;
    endcase
  end

  // sample bundle
  always_comb begin
    in_data.acc_x  = acc_x_i;
    in_data.acc_y  = acc_y_i;
    in_data.acc_z  = acc_z_i;
    in_data.rate_x = rate_x_i;
    in_data.rate_y = rate_y_i;
    in_data.rate_z = rate_z_i;
  end

  tcf_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data),
    .q_valid_o  (q_valid),
    .q_pop_i    (q_pop),
    .q_data_o   (q_data)
  );

  tcf_engine u_engine (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_data_i      (q_data),
    .q_pop_o       (q_pop),
    .cfg_i         (cfg_q),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .roll_out_o    (roll_out_o),
    .pitch_out_o   (pitch_out_o),
    .yaw_out_o     (yaw_out_o),
    .flag_left_o   (flag_left_o),
    .flag_right_o  (flag_right_o),
    .flag_top_o    (flag_top_o),
    .flag_bottom_o (flag_bottom_o)
  );

endmodule

### design/tcf_front.sv
// input side: accepts samples into a two-entry queue toward the engine
module tcf_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  tcf_pkg::sample_t  in_data_i,
  output logic              q_valid_o,
  input  logic              q_pop_i,
  output tcf_pkg::sample_t  q_data_o
);

  tcf_pkg::sample_t entry_q [tcf_pkg::Q_DEPTH];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       push, pop;

  assign in_stall_o = (count_q == 2'(tcf_pkg::Q_DEPTH));
  assign q_valid_o  = (count_q != 2'd0);
  assign q_data_o   = entry_q[rd_ptr_q];
  assign push       = in_valid_i && !in_stall_o;
  assign pop        = q_pop_i && q_valid_o;

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      count_q <= 2'(count_q + {1'b0, push} - {1'b0, pop});
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) entry_q[wr_ptr_q] <= in_data_i;
  end

endmodule

### design/tcf_cordic.sv
// iterative vectoring cordic: atan2(y, x) in 1/65536 degree
module tcf_cordic (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start_i,
  input  logic signed [tcf_pkg::IN_W-1:0]        y_i,
  input  logic signed [tcf_pkg::IN_W-1:0]        x_i,
  output logic                                   done_o,
  output logic signed [tcf_pkg::ANG_W-1:0]       angle_o
);

  logic                                busy_q, done_q, zero_q;
  logic [tcf_pkg::ITER_W-1:0]          cnt_q;
  logic signed [tcf_pkg::VEC_W-1:0]    x_q, y_q, xe, ye, x0, y0, xs, ys;
  logic signed [tcf_pkg::ANG_W-1:0]    z_q, z0, atan_v;
  logic                                last_iter;

  assign last_iter = (cnt_q == tcf_pkg::ITER_W'(tcf_pkg::CORDIC_ITERS - 1));
  assign done_o    = done_q;
  assign angle_o   = zero_q ? '0 : z_q;

  // scale up and pre-rotate into the right half plane
  always_comb begin
    xe = tcf_pkg::VEC_W'(x_i) <<< tcf_pkg::PRE_SHIFT;
    ye = tcf_pkg::VEC_W'(y_i) <<< tcf_pkg::PRE_SHIFT;
    x0 = xe;
    y0 = ye;
    z0 = '0;
    if (xe < 0) begin
      if (ye >= 0) begin
        x0 = ye;
        y0 = -xe;
        z0 = tcf_pkg::ANG_90;
      end else begin
        x0 = -ye;
        y0 = xe;
        z0 = -tcf_pkg::ANG_90;
      end
    end
  end

  // one micro-rotation per cycle
  assign xs     = x_q >>> cnt_q;
  assign ys     = y_q >>> cnt_q;
  assign atan_v = tcf_pkg::ANG_W'(tcf_pkg::atan_deg16(cnt_q));

  // iteration control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (last_iter) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // vector and angle registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q    <= x0;
      y_q    <= y0;
      z_q    <= z0;
      zero_q <= (x_i == '0) && (y_i == '0);
    end else if (busy_q) begin
      if (y_q >= 0) begin
        x_q <= x_q + ys;
        y_q <= y_q - xs;
        z_q <= z_q + atan_v;
      end else begin
        x_q <= x_q - ys;
        y_q <= y_q + xs;
        z_q <= z_q - atan_v;
      end
    end
  end

endmodule

### design/tcf_engine.sv
// back end: tilt angles, gyro integration, blend and output register
module tcf_engine (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  input  tcf_pkg::sample_t  q_data_i,
  output logic              q_pop_o,
  input  tcf_pkg::cfg_t     cfg_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic signed [16:0] roll_out_o,
  output logic signed [16:0] pitch_out_o,
  output logic signed [16:0] yaw_out_o,
  output logic              flag_left_o,
  output logic              flag_right_o,
  output logic              flag_top_o,
  output logic              flag_bottom_o
);

  tcf_pkg::eng_state_e state_q, state_d;
  tcf_pkg::sample_t    cur_q;

  logic [2:0] op_q;
  logic       pop, cordic_go, pitch_sel, load_out, out_free;

  // shared multiplier
  logic signed [tcf_pkg::MUL_A_W-1:0] mul_a;
  logic signed [tcf_pkg::MUL_B_W-1:0] mul_b;
  logic signed [tcf_pkg::PROD_W-1:0]  prod_q;
  logic signed [tcf_pkg::PROD_W-1:0]  acc_q;

  // square root
  logic [31:0] sq_q;
  logic [39:0] rad_q;
  logic [23:0] rem_q, rem_t, trial;
  logic [19:0] root_q;
  logic [4:0]  sqrt_cnt_q;

  // gyro step division by 131
  logic [30:0] mag_q  [tcf_pkg::NUM_AXES];
  logic [32:0] step_q [tcf_pkg::NUM_AXES];
  logic [62:0] recip_q;
  logic [23:0] q1_q;
  logic [7:0]  r1_q;
  logic [30:0] q1_back;
  logic [15:0] frac_num;
  logic [32:0] frac_prod;
  logic        div_busy_q;
  logic [1:0]  div_lane_q, div_ph_q;

  // cordic hookup
  logic                                  cordic_done;
  logic signed [tcf_pkg::IN_W-1:0]       cy, cx;
  logic signed [tcf_pkg::ANG_W-1:0]      cordic_ang, roll_acc_q, pitch_acc_q;

  // filter state
  logic signed [16:0] last_q [tcf_pkg::NUM_AXES];

  // blend helpers
  logic [16:0]        alpha;
  logic [1:0]         axis;
  logic signed [15:0] rate_sel;
  logic signed [tcf_pkg::MUL_A_W-1:0] step_s, pred, acc24;
  logic signed [tcf_pkg::ANG_W-1:0]   acc_ang;
  logic signed [tcf_pkg::PROD_W:0]    sum, sum_r;
  logic signed [22:0]                 blend_r;
  logic signed [16:0]                 blend_sat;

  assign alpha    = (cfg_i.blend_weight > tcf_pkg::ALPHA_ONE) ? tcf_pkg::ALPHA_ONE
                                                               : cfg_i.blend_weight;
  assign out_free = !out_valid_o || !out_stall_i;
  assign q_pop_o  = pop;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      tcf_pkg::ST_IDLE:     if (q_valid_i) state_d = tcf_pkg::ST_MUL_A;
      tcf_pkg::ST_MUL_A:    if (op_q == tcf_pkg::OP_A_LAST) state_d = tcf_pkg::ST_SQRT;
      tcf_pkg::ST_SQRT:     if (sqrt_cnt_q == 5'd0) state_d = tcf_pkg::ST_ROLL_GO;
      tcf_pkg::ST_ROLL_GO:  state_d = tcf_pkg::ST_ROLL;
      tcf_pkg::ST_ROLL:     if (cordic_done) state_d = tcf_pkg::ST_PITCH_GO;
      tcf_pkg::ST_PITCH_GO: state_d = tcf_pkg::ST_PITCH;
      tcf_pkg::ST_PITCH:    if (cordic_done) state_d = tcf_pkg::ST_DIV_WAIT;
      tcf_pkg::ST_DIV_WAIT: if (!div_busy_q) state_d = tcf_pkg::ST_MUL_B;
      tcf_pkg::ST_MUL_B:    if (op_q == tcf_pkg::OP_B_LAST) state_d = tcf_pkg::ST_OUT;
      tcf_pkg::ST_OUT:      if (out_free) state_d = tcf_pkg::ST_IDLE;
      default:              state_d = tcf_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    pop       = 1'b0;
    cordic_go = 1'b0;
    pitch_sel = 1'b0;
    load_out  = 1'b0;
    case (state_q)
      tcf_pkg::ST_IDLE:     pop = q_valid_i;
      tcf_pkg::ST_ROLL_GO:  cordic_go = 1'b1;
      tcf_pkg::ST_PITCH_GO: begin
        cordic_go = 1'b1;
        pitch_sel = 1'b1;
      end
      tcf_pkg::ST_OUT:      load_out = out_free;
      default:              ;
    endcase
  end

  // cordic operands
  always_comb begin
    if (pitch_sel) begin
      cy = -(tcf_pkg::IN_W'(cur_q.acc_x) <<< 4);
      cx = $signed({1'b0, root_q});
    end else begin
      cy = tcf_pkg::IN_W'(cur_q.acc_y);
      cx = tcf_pkg::IN_W'(cur_q.acc_z);
    end
  end

  tcf_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cordic_go),
    .y_i     (cy),
    .x_i     (cx),
    .done_o  (cordic_done),
    .angle_o (cordic_ang)
  );

  // per-axis operands for the multiplier
  always_comb begin
    axis = (op_q[2:1] == 2'd3) ? 2'd2 : op_q[2:1];
    case (axis)
      2'd0:    begin rate_sel = cur_q.rate_x; acc_ang = roll_acc_q;  end
      2'd1:    begin rate_sel = cur_q.rate_y; acc_ang = pitch_acc_q; end
      default: begin rate_sel = cur_q.rate_z; acc_ang = '0;          end
    endcase
    step_s   = $signed({3'b000, step_q[axis]});
    if (rate_sel[15]) step_s = -step_s;
    pred  = (tcf_pkg::MUL_A_W'(last_q[axis]) <<< 16) + step_s;
    acc24 = tcf_pkg::MUL_A_W'(acc_ang) <<< 8;
  end

  // gyro operand for the products rate times period
  logic [16:0] gyro_abs;
  always_comb begin
    case (op_q)
      3'd2:    gyro_abs = cur_q.rate_x[15] ? 17'(-17'(cur_q.rate_x)) : 17'(cur_q.rate_x);
      3'd3:    gyro_abs = cur_q.rate_y[15] ? 17'(-17'(cur_q.rate_y)) : 17'(cur_q.rate_y);
      default: gyro_abs = cur_q.rate_z[15] ? 17'(-17'(cur_q.rate_z)) : 17'(cur_q.rate_z);
    endcase
  end

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_q == tcf_pkg::ST_MUL_A) begin
      case (op_q)
        3'd0: begin
          mul_a = tcf_pkg::MUL_A_W'(cur_q.acc_y);
          mul_b = tcf_pkg::MUL_B_W'(cur_q.acc_y);
        end
        3'd1: begin
          mul_a = tcf_pkg::MUL_A_W'(cur_q.acc_z);
          mul_b = tcf_pkg::MUL_B_W'(cur_q.acc_z);
        end
        3'd2, 3'd3, 3'd4: begin
          mul_a = $signed({19'd0, gyro_abs});
          mul_b = $signed({2'b00, cfg_i.sample_period});
        end
        default: ;
      endcase
    end else if (state_q == tcf_pkg::ST_MUL_B && op_q != tcf_pkg::OP_B_LAST) begin
      if (!op_q[0]) begin
        mul_a = pred;
        mul_b = $signed({1'b0, alpha});
      end else begin
        mul_a = acc24;
        mul_b = $signed({1'b0, 17'(tcf_pkg::ALPHA_ONE - alpha)});
      end
    end
  end

  // rounding and saturation of the blended angle
  always_comb begin
    sum     = (tcf_pkg::PROD_W + 1)'(acc_q) + (tcf_pkg::PROD_W + 1)'(prod_q);
    sum_r   = sum + (tcf_pkg::PROD_W + 1)'(64'sd2147483648);
    blend_r = sum_r[tcf_pkg::PROD_W:32];
    if (blend_r > 23'(tcf_pkg::ANG_MAX))        blend_sat = tcf_pkg::ANG_MAX;
    else if (blend_r < -23'(tcf_pkg::ANG_MAX))  blend_sat = -tcf_pkg::ANG_MAX;
    else                                        blend_sat = blend_r[16:0];
  end

  // square root digit step
  assign rem_t = {rem_q[21:0], rad_q[39:38]};
  assign trial = {2'b00, root_q, 2'b01};

  // division by 131: coarse quotient back-multiplied, then the rounding digit
  assign q1_back   = 31'(recip_q[62:tcf_pkg::RECIP_SHIFT]) * 31'(tcf_pkg::GYRO_DIV);
  assign frac_num  = {r1_q, 8'd0} + tcf_pkg::GYRO_ROUND;
  assign frac_prod = 33'(frac_num) * 33'(tcf_pkg::RECIP2_M);

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tcf_pkg::ST_IDLE;
      op_q        <= '0;
      sqrt_cnt_q  <= '0;
      div_busy_q  <= 1'b0;
      div_lane_q  <= '0;
      div_ph_q    <= '0;
      out_valid_o <= 1'b0;
      for (int a = 0; a < tcf_pkg::NUM_AXES; a++) last_q[a] <= '0;
    end else begin
      state_q <= state_d;
      if ((state_q == tcf_pkg::ST_MUL_A || state_q == tcf_pkg::ST_MUL_B) &&
          state_d == state_q) begin
        op_q <= op_q + 1'b1;
      end else begin
        op_q <= '0;
      end
      if (state_q == tcf_pkg::ST_MUL_A && op_q == tcf_pkg::OP_A_LAST) begin
        sqrt_cnt_q <= 5'(tcf_pkg::SQRT_STEPS);
        div_busy_q <= 1'b1;
        div_lane_q <= '0;
        div_ph_q   <= '0;
      end else begin
        if (state_q == tcf_pkg::ST_SQRT && sqrt_cnt_q != 5'd0) sqrt_cnt_q <= sqrt_cnt_q - 1'b1;
        // three phases per axis, axes in turn
        if (div_busy_q) begin
          if (div_ph_q == 2'd2) begin
            div_ph_q   <= '0;
            div_lane_q <= div_lane_q + 1'b1;
            if (div_lane_q == 2'(tcf_pkg::NUM_AXES - 1)) div_busy_q <= 1'b0;
          end else begin
            div_ph_q <= div_ph_q + 1'b1;
          end
        end
      end
      // filtered angle lands after the second product of each axis
      if (state_q == tcf_pkg::ST_MUL_B && op_q != 3'd0 && !op_q[0]) begin
        case (op_q)
          3'd2:    last_q[0] <= blend_sat;
          3'd4:    last_q[1] <= blend_sat;
          default: last_q[2] <= blend_sat;
        endcase
      end
      if (load_out) out_valid_o <= 1'b1;
      else if (!out_stall_i) out_valid_o <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    if (pop) cur_q <= q_data_i;

    if (state_q == tcf_pkg::ST_MUL_A) begin
      case (op_q)
        3'd1: sq_q <= prod_q[31:0];
        3'd2: sq_q <= sq_q + prod_q[31:0];
        3'd3: mag_q[0] <= prod_q[30:0];
        3'd4: mag_q[1] <= prod_q[30:0];
        3'd5: begin
          mag_q[2] <= prod_q[30:0];
          rad_q    <= {sq_q, 8'd0};
          rem_q    <= '0;
          root_q   <= '0;
        end
        default: ;
      endcase
    end

    // gyro step: reciprocal product, remainder, then final quotient
    if (div_busy_q) begin
      case (div_ph_q)
        2'd0: recip_q <= 63'(mag_q[div_lane_q]) * 63'(tcf_pkg::RECIP_M);
        2'd1: begin
          q1_q <= recip_q[62:tcf_pkg::RECIP_SHIFT];
          r1_q <= 8'(mag_q[div_lane_q] - q1_back);
        end
        default: step_q[div_lane_q] <= {1'b0, q1_q, 8'd0} + 33'(frac_prod[32:24]);
      endcase
    end

    if (state_q == tcf_pkg::ST_SQRT && sqrt_cnt_q != 5'd0) begin
      rad_q <= {rad_q[37:0], 2'b00};
      if (rem_t >= trial) begin
        rem_q  <= rem_t - trial;
        root_q <= {root_q[18:0], 1'b1};
      end else begin
        rem_q  <= rem_t;
        root_q <= {root_q[18:0], 1'b0};
      end
    end

    if (state_q == tcf_pkg::ST_ROLL && cordic_done)  roll_acc_q  <= cordic_ang;
    if (state_q == tcf_pkg::ST_PITCH && cordic_done) pitch_acc_q <= cordic_ang;

    // first product of each axis is held for the sum
    if (state_q == tcf_pkg::ST_MUL_B && op_q[0]) acc_q <= prod_q;

    if (load_out) begin
      roll_out_o    <= last_q[0];
      pitch_out_o   <= last_q[1];
      yaw_out_o     <= last_q[2];
      flag_left_o   <= last_q[0] < $signed({cfg_i.left_limit, 8'h00});
      flag_right_o  <= last_q[0] > $signed({cfg_i.right_limit, 8'h00});
      flag_top_o    <= last_q[1] > $signed({cfg_i.top_limit, 8'h00});
      flag_bottom_o <= last_q[1] < $signed({cfg_i.bottom_limit, 8'h00});
    end
  end

endmodule

### design/tcf_checker.sv
// port-level checks for the tilt filter, bound to the top level
module tcf_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               pready,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic signed [16:0] roll_out_o,
  input logic signed [16:0] pitch_out_o,
  input logic signed [16:0] yaw_out_o,
  input logic               flag_left_o,
  input logic               flag_right_o,
  input logic               flag_top_o,
  input logic               flag_bottom_o
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // a stalled result does not change
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(roll_out_o) && $stable(pitch_out_o) &&
      $stable(yaw_out_o) && $stable(flag_left_o) && $stable(flag_right_o) &&
      $stable(flag_top_o) && $stable(flag_bottom_o))
    else $error("result changed while stalled");

  // angles are saturated to half a turn
  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> roll_out_o <= 17'sd46080 && roll_out_o >= -17'sd46080 &&
      pitch_out_o <= 17'sd46080 && pitch_out_o >= -17'sd46080 &&
      yaw_out_o <= 17'sd46080 && yaw_out_o >= -17'sd46080)
    else $error("angle outside saturation range");

  // register port never inserts wait states
  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

endmodule

bind tilt_complementary_filter_top tcf_checker u_tcf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .pready        (pready),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .roll_out_o    (roll_out_o),
  .pitch_out_o   (pitch_out_o),
  .yaw_out_o     (yaw_out_o),
  .flag_left_o   (flag_left_o),
  .flag_right_o  (flag_right_o),
  .flag_top_o    (flag_top_o),
  .flag_bottom_o (flag_bottom_o)
);

### tb/tb_tilt_complementary_filter_top.sv
// testbench for the tilt complementary filter: random and directed samples checked against a predictor
module tb_tilt_complementary_filter_top;
  import tcf_pkg::*;

  typedef struct packed {
    logic signed [16:0] roll;
    logic signed [16:0] pitch;
    logic signed [16:0] yaw;
    logic               left;
    logic               right;
    logic               top;
    logic               bottom;
  } attitude_t;

  logic               clk_i;
  logic               rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [4:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid_i;
  logic               in_stall_o;
  logic signed [15:0] acc_x_i;
  logic signed [15:0] acc_y_i;
  logic signed [15:0] acc_z_i;
  logic signed [15:0] rate_x_i;
  logic signed [15:0] rate_y_i;
  logic signed [15:0] rate_z_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic signed [16:0] roll_out_o;
  logic signed [16:0] pitch_out_o;
  logic signed [16:0] yaw_out_o;
  logic               flag_left_o;
  logic               flag_right_o;
  logic               flag_top_o;
  logic               flag_bottom_o;

  tilt_complementary_filter_top u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .acc_x_i      (acc_x_i),
    .acc_y_i      (acc_y_i),
    .acc_z_i      (acc_z_i),
    .rate_x_i     (rate_x_i),
    .rate_y_i     (rate_y_i),
    .rate_z_i     (rate_z_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .roll_out_o   (roll_out_o),
    .pitch_out_o  (pitch_out_o),
    .yaw_out_o    (yaw_out_o),
    .flag_left_o  (flag_left_o),
    .flag_right_o (flag_right_o),
    .flag_top_o   (flag_top_o),
    .flag_bottom_o(flag_bottom_o)
  );

  // arctangent of 2^-i in 1/65536 degree
  localparam longint ATAN_TBL [24] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  // shadow registers and filter angles
  longint gyro_weight;
  longint period_q16;
  longint lim_left;
  longint lim_right;
  longint lim_top;
  longint lim_bottom;
  longint prev_roll;
  longint prev_pitch;
  longint prev_yaw;

  sample_t   pending_samples[$];
  attitude_t expected_attitudes[$];
  int        fail_cnt;
  int        idle_pct;
  int        stall_pct;
  bit        hold_off;
  bit        in_fire;

  // clock
  initial clk_i = 1'b0;
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic longint floor_sqrt(longint v);
    longint r;
    longint b;
    r = 0;
    b = longint'(1) << 40;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // vectoring cordic, angle in 1/65536 degree
  function automatic longint vector_angle(longint y, longint x);
    longint z;
    longint t;
    longint xs;
    longint ys;
    z = 0;
    if (x == 0 && y == 0) return 0;
    x = x * 4096;
    y = y * 4096;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y;
        y = -t;
        z = 90 * 65536;
      end else begin
        x = -y;
        y = t;
        z = -90 * 65536;
      end
    end
    for (int i = 0; i < CORDIC_ITERS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z = z + ATAN_TBL[i];
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - ATAN_TBL[i];
      end
    end
    return z;
  endfunction

  // gyro-predicted angle blended with the accelerometer angle
  function automatic longint blend_axis(longint prev, longint acc16, longint raw, longint alpha);
    longint mag;
    longint step;
    longint sum;
    longint r;
    mag = (raw < 0 ? -raw : raw) * period_q16 * 256;
    step = (mag + 65) / 131;
    if (raw < 0) step = -step;
    sum = alpha * (prev * 65536 + step) + (65536 - alpha) * (acc16 * 256);
    r = (sum + (longint'(1) << 31)) >>> 32;
    if (r > 46080) r = 46080;
    if (r < -46080) r = -46080;
    return r;
  endfunction

  function automatic attitude_t predict_attitude(sample_t s);
    attitude_t a;
    longint alpha;
    longint ay;
    longint az;
    longint mag4;
    longint roll;
    longint pitch;
    longint yaw;
    alpha = gyro_weight > 65536 ? 65536 : gyro_weight;
    ay = s.acc_y;
    az = s.acc_z;
    mag4 = floor_sqrt((ay * ay + az * az) << 8);
    roll = blend_axis(prev_roll, vector_angle(ay, az), s.rate_x, alpha);
    pitch = blend_axis(prev_pitch, vector_angle(-longint'(s.acc_x) * 16, mag4),
                       s.rate_y, alpha);
    yaw = blend_axis(prev_yaw, 0, s.rate_z, alpha);
    prev_roll = roll;
    prev_pitch = pitch;
    prev_yaw = yaw;
    a.roll = roll[16:0];
    a.pitch = pitch[16:0];
    a.yaw = yaw[16:0];
    a.left = roll < lim_left * 256;
    a.right = roll > lim_right * 256;
    a.top = pitch > lim_top * 256;
    a.bottom = pitch < lim_bottom * 256;
    return a;
  endfunction

  function automatic sample_t make_sample(int ax, int ay, int az, int gx, int gy, int gz);
    sample_t s;
    s.acc_x = 16'(ax);
    s.acc_y = 16'(ay);
    s.acc_z = 16'(az);
    s.rate_x = 16'(gx);
    s.rate_y = 16'(gy);
    s.rate_z = 16'(gz);
    return s;
  endfunction

  // mostly near-gravity tilts with moderate rates, the rest full range
  function automatic sample_t random_sample();
    if ($urandom_range(2) == 0) return sample_t'({$urandom, $urandom, $urandom});
    return make_sample($urandom_range(34000) - 17000, $urandom_range(34000) - 17000,
                       $urandom_range(34000) - 17000, $urandom_range(8000) - 4000,
                       $urandom_range(8000) - 4000, $urandom_range(8000) - 4000);
  endfunction

  // register write over the apb port
  task automatic reg_write(logic [2:0] idx, int value);
    @(negedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= 32'(value);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      REG_BLEND_WEIGHT:  gyro_weight = longint'(pwdata[16:0]);
      REG_SAMPLE_PERIOD: period_q16 = longint'(pwdata[15:0]);
      REG_LEFT_LIMIT:    lim_left = longint'($signed(pwdata[8:0]));
      REG_RIGHT_LIMIT:   lim_right = longint'($signed(pwdata[8:0]));
      REG_TOP_LIMIT:     lim_top = longint'($signed(pwdata[8:0]));
      REG_BOTTOM_LIMIT:  lim_bottom = longint'($signed(pwdata[8:0]));
      default: ;
    endcase
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic write_all(int w, int p, int l, int r, int t, int b);
    reg_write(REG_BLEND_WEIGHT, w);
    reg_write(REG_SAMPLE_PERIOD, p);
    reg_write(REG_LEFT_LIMIT, l);
    reg_write(REG_RIGHT_LIMIT, r);
    reg_write(REG_TOP_LIMIT, t);
    reg_write(REG_BOTTOM_LIMIT, b);
  endtask

  // wait until every sample is in and every result is out
  task automatic drain();
    while (pending_samples.size() != 0 || in_valid_i || expected_attitudes.size() != 0)
      @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  // input driver
  always @(negedge clk_i) begin
    sample_t cur;
    if (rst_ni) begin
      if (!in_valid_i || in_fire) begin
        if (!hold_off && pending_samples.size() != 0 && $urandom_range(99) >= idle_pct) begin
          cur = pending_samples.pop_front();
          in_valid_i <= 1'b1;
          acc_x_i <= cur.acc_x;
          acc_y_i <= cur.acc_y;
          acc_z_i <= cur.acc_z;
          rate_x_i <= cur.rate_x;
          rate_y_i <= cur.rate_y;
          rate_z_i <= cur.rate_z;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  // monitor: predict on each input transaction, check each output transaction
  always @(posedge clk_i) begin
    attitude_t exp_a;
    attitude_t got;
    in_fire = rst_ni && in_valid_i && !in_stall_o;
    if (in_fire) begin
      expected_attitudes.push_back(predict_attitude(
        make_sample(acc_x_i, acc_y_i, acc_z_i, rate_x_i, rate_y_i, rate_z_i)));
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{roll_out_o, pitch_out_o, yaw_out_o, flag_left_o, flag_right_o,
              flag_top_o, flag_bottom_o};
      if (expected_attitudes.size() == 0) begin
        $display("%0t: unexpected result, actual %p", $time, got);
        fail_cnt++;
      end else begin
        exp_a = expected_attitudes.pop_front();
        if (got !== exp_a) begin
          $display("%0t: result differs, expected %p actual %p", $time, exp_a, got);
          fail_cnt++;
        end
      end
    end
  end

  // stimulus
  initial begin
    fail_cnt = 0;
    idle_pct = 0;
    stall_pct = 0;
    hold_off = 1'b0;
    in_fire = 1'b0;
    gyro_weight = 64225;
    period_q16 = 6554;
    lim_left = -10;
    lim_right = 10;
    lim_top = 10;
    lim_bottom = -10;
    prev_roll = 0;
    prev_pitch = 0;
    prev_yaw = 0;
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid_i = 1'b0;
    out_stall_i = 1'b0;
    acc_x_i = '0;
    acc_y_i = '0;
    acc_z_i = '0;
    rate_x_i = '0;
    rate_y_i = '0;
    rate_z_i = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: zero vector, field extremes, negative-x quadrants, level poses
    pending_samples.push_back(make_sample(0, 0, 0, 0, 0, 0));
    pending_samples.push_back(make_sample(32767, 32767, 32767, 32767, 32767, 32767));
    pending_samples.push_back(make_sample(-32768, -32768, -32768, -32768, -32768, -32768));
    pending_samples.push_back(make_sample(0, 0, -16384, 0, 0, 0));
    pending_samples.push_back(make_sample(0, -16384, -16384, 0, 0, 0));
    pending_samples.push_back(make_sample(0, 16384, -16384, 131, -131, 0));
    pending_samples.push_back(make_sample(16384, 0, 0, 0, 0, 0));
    pending_samples.push_back(make_sample(-16384, 0, 0, 0, 0, 0));
    pending_samples.push_back(make_sample(0, 0, 16384, 0, 0, 0));
    pending_samples.push_back(make_sample(-32768, 0, 0, -32768, 32767, 32767));
    pending_samples.push_back(make_sample(32767, -32768, 0, 32767, -32768, -32768));
    pending_samples.push_back(make_sample(0, 16384, 0, 0, 0, 0));
    pending_samples.push_back(make_sample(0, -16384, 0, 0, 0, 0));
    pending_samples.push_back(make_sample(1, -1, -1, 1, -1, 1));
    drain();

    // random phases, each with its own register setting and an idle and stall mode
    for (int ph = 1; ph <= 6; ph++) begin
      case (ph)
        1: write_all(64225, 6554, -10, 10, 10, -10);
        2: write_all(0, 65535, -256, 255, 255, -256);
        3: write_all(65536, 0, -180, 180, 180, -180);
        4: write_all(131071, 1, 0, 0, 0, 0);
        5: write_all($urandom_range(131071), $urandom_range(65535),
                     $urandom_range(511), $urandom_range(511),
                     $urandom_range(511), $urandom_range(511));
        default: write_all(62000, 3277, -5, 5, 5, -5);
      endcase
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 50; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 50; end
        default: begin idle_pct = 12; stall_pct = 12; end
      endcase
      for (int i = 0; i < 200; i++) pending_samples.push_back(random_sample());
      // hold the sender once until every result is back
      if (ph == 2) begin
        while (pending_samples.size() > 100) @(posedge clk_i);
        hold_off = 1'b1;
        while (in_valid_i || expected_attitudes.size() != 0) @(posedge clk_i);
        hold_off = 1'b0;
      end
      drain();
    end

    if (fail_cnt == 0) begin
      $display("tilt_complementary_filter_top: match");
    end else begin
      $display("tilt_complementary_filter_top: mismatch");
    end
    $finish;
  end

  // run limit
  initial begin
    #60000000;
    $display("tilt_complementary_filter_top: mismatch");
    $finish;
  end

endmodule
